/* sv/fpct_pkg.sv */
package fpct_pkg;

  localparam int ENTRIES    = 32;
  localparam int SLOT_W     = $clog2(ENTRIES);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int PAGE_BYTES = 4096;
  localparam int FILE_ID_W  = 16;
  localparam int OFFSET_W   = 48;
  localparam int LENGTH_W   = 13;
  localparam int OP_W       = 2;

  localparam logic [LENGTH_W-1:0] PAGE_LEN = LENGTH_W'(PAGE_BYTES);

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_FILL   = 2'd1,
    OP_INVAL  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FILE_ID_W-1:0] file;
    logic [OFFSET_W-1:0]  offset;
    logic [LENGTH_W-1:0]  length;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              stored;
  } result_t;

endpackage

/* sv/fpct_tag_ram.sv */
module fpct_tag_ram
  import fpct_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/fpct_ctrl.sv */
module fpct_ctrl
  import fpct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [FILE_ID_W-1:0] in_file_id,
  input  logic [OFFSET_W-1:0]  in_byte_offset,
  input  logic [LENGTH_W-1:0]  in_length,
  input  logic                 out_free,
  output ram_wr_t              ram_wr,
  output logic                 rd_en,
  output logic [SLOT_W-1:0]    rd_addr,
  input  entry_t               rd_data,
  output result_t              res
);

  state_t state_r, state_nxt;

  op_t                  req_op_r, req_op_nxt;
  logic [FILE_ID_W-1:0] req_file_r, req_file_nxt;
  logic [OFFSET_W-1:0]  req_off_r, req_off_nxt;
  logic [LENGTH_W-1:0]  req_len_r, req_len_nxt;

  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [SLOT_W-1:0]    next_slot_r, next_slot_nxt;

  logic                 res_hit_r, res_hit_nxt;
  logic [SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic                 res_stored_r, res_stored_nxt;

  logic accept;
  logic fill_ok;
  logic start_scan;
  logic file_match;
  logic hit_now;
  logic scan_last;

  assign accept     = in_valid && (state_r == ST_IDLE);
  assign fill_ok    = (in_length != '0) && (in_length <= PAGE_LEN);
  assign start_scan = ((in_operation == OP_LOOKUP) && (in_length <= PAGE_LEN)) ||
                      (in_operation == OP_INVAL);

  // Compare stage works on the entry read in the previous cycle.
  assign file_match = cmp_vld_r && valid_r[cmp_idx_r] && (rd_data.file == req_file_r);
  assign hit_now    = file_match && (req_op_r == OP_LOOKUP) &&
                      (rd_data.offset == req_off_r) && (rd_data.length >= req_len_r);
  assign scan_last  = cmp_vld_r && (cmp_idx_r == SLOT_W'(ENTRIES - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = start_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (hit_now || scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    ram_wr.en      = 1'b0;
    ram_wr.addr    = next_slot_r;
    ram_wr.data    = '{file: in_file_id, offset: in_byte_offset, length: in_length};
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[SLOT_W-1:0];
    req_op_nxt     = req_op_r;
    req_file_nxt   = req_file_r;
    req_off_nxt    = req_off_r;
    req_len_nxt    = req_len_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    valid_nxt      = valid_r;
    next_slot_nxt  = next_slot_r;
    res_hit_nxt    = res_hit_r;
    res_slot_nxt   = res_slot_r;
    res_stored_nxt = res_stored_r;
    res.vld        = (state_r == ST_DONE);
    res.hit        = res_hit_r;
    res.slot       = res_slot_r;
    res.stored     = res_stored_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_op_nxt     = op_t'(in_operation);
          req_file_nxt   = in_file_id;
          req_off_nxt    = in_byte_offset;
          req_len_nxt    = in_length;
          rd_idx_nxt     = '0;
          res_hit_nxt    = 1'b0;
          res_slot_nxt   = '0;
          res_stored_nxt = 1'b0;
          if ((in_operation == OP_FILL) && fill_ok) begin
            ram_wr.en              = 1'b1;
            valid_nxt[next_slot_r] = 1'b1;
            next_slot_nxt          = (next_slot_r == SLOT_W'(ENTRIES - 1)) ?
                                     '0 : next_slot_r + 1'b1;
            res_slot_nxt           = next_slot_r;
            res_stored_nxt         = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        rd_en       = (rd_idx_r < CNT_W'(ENTRIES));
        rd_idx_nxt  = rd_idx_r + CNT_W'(rd_en);
        cmp_vld_nxt = rd_en;
        cmp_idx_nxt = rd_idx_r[SLOT_W-1:0];
        if (file_match && (req_op_r == OP_INVAL)) begin
          valid_nxt[cmp_idx_r] = 1'b0;
        end
        if (hit_now) begin
          res_hit_nxt  = 1'b1;
          res_slot_nxt = cmp_idx_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      next_slot_r <= '0;
      cmp_vld_r   <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      next_slot_r <= next_slot_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      rd_idx_r    <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_op_r     <= req_op_nxt;
    req_file_r   <= req_file_nxt;
    req_off_r    <= req_off_nxt;
    req_len_r    <= req_len_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_hit_r    <= res_hit_nxt;
    res_slot_r   <= res_slot_nxt;
    res_stored_r <= res_stored_nxt;
  end

endmodule

/* sv/file_page_cache_tags.sv */
// Channel  Ports                                              Direction
// -------  -------------------------------------------------  ---------
// in       in_valid, in_stall, in_operation, in_file_id,      input
//          in_byte_offset, in_length
// out      out_valid, out_stall, out_hit, out_slot, out_stored output
//
// A fill or a rejected request goes straight from idle to the done state, then into the output register.
// A lookup scans the tag RAM one entry per cycle through its single read port and
// stops at the first hit; an invalidate always scans every entry.
// Reset clears the valid bits and the fill pointer at once; tag contents need no clearing.
// A new beat is taken while the previous result waits in the output register under stall.
module file_page_cache_tags
  import fpct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [FILE_ID_W-1:0] in_file_id,
  input  logic [OFFSET_W-1:0]  in_byte_offset,
  input  logic [LENGTH_W-1:0]  in_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [SLOT_W-1:0]    out_slot,
  output logic                 out_stored
);

  ram_wr_t           ram_wr;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd_data;
  result_t           res;
  logic              out_free;

  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_stored_r;

  assign out_free = !out_valid_r || !out_stall;

  fpct_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_file_id     (in_file_id),
    .in_byte_offset (in_byte_offset),
    .in_length      (in_length),
    .out_free       (out_free),
    .ram_wr         (ram_wr),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .res            (res)
  );

  fpct_tag_ram u_tag_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.vld && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld && out_free) begin
      out_hit_r    <= res.hit;
      out_slot_r   <= res.slot;
      out_stored_r <= res.stored;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_slot   = out_slot_r;
  assign out_stored = out_stored_r;

endmodule
